@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/mrrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrrp_pkg
// types, codes and the crc-16 byte update of the modbus rtu reply parser
// ----------------------------------------------------------------------------
`default_nettype none

package mrrp_pkg;

   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_TIMEOUT = 2'd1;
   localparam logic [1:0] ACT_FLUSH   = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_HDR_TIMEOUT = 3'd1;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
   localparam logic [2:0] ST_TOO_LONG    = 3'd3;
   localparam logic [2:0] ST_BODY_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_CRC_ERROR   = 3'd5;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [7:0] FC_READ_COILS    = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT    = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
   localparam logic [7:0] FC_WRITE_REG     = 8'h06;
   localparam logic [7:0] FC_DIAG          = 8'h08;
   localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS    = 8'h10;
   localparam logic [7:0] FC_ENCAP         = 8'h2B;
   localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;

   localparam logic [8:0] LEN_OVERHEAD  = 9'd5;
   localparam logic [8:0] LEN_FIXED     = 9'd8;
   localparam logic [8:0] LEN_EXCEPTION = 9'd5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic CSR_MAX_FRAME_LEN = 1'b0;
   localparam logic CSR_REG_CAPACITY  = 1'b1;

   localparam logic [8:0] MAX_FRAME_LEN_RESET = 9'd300;
   localparam logic [7:0] REG_CAPACITY_RESET  = 8'd160;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  reg_index;
      logic [15:0] reg_value;
      logic [2:0]  status;
      logic [8:0]  frame_len;
      logic [7:0]  slave_addr;
      logic [7:0]  code_byte;
   } rsp_item_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ design/modbus_rtu_response_parser_core.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser_core
// parses modbus rtu reply bytes, checks crc-16, emits register words and status
// an accepted item waits in the input register until it advances; any result is written to the output register
// throughput: one item per cycle unless the output stalls, one input register and one result register
// reset: synchronous, clears frame state and restores both csr registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modbus_rtu_response_parser_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire mrrp_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output mrrp_pkg::rsp_item_type     rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [8:0]            csr_wdata
);
   import mrrp_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [8:0]   max_len_ff;
   logic [7:0]   reg_cap_ff;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic [1:0]   phase_ff, phase_in;
   logic [8:0]   pos_ff, pos_in;
   logic [15:0]  crc_ff, crc_in;
   logic [8:0]   exp_len_ff, exp_len_in;
   logic [7:0]   addr_ff, addr_in;
   logic [7:0]   code_ff, code_in;
   logic [7:0]   hi_ff, hi_in;
   logic [7:0]   crc_lo_ff, crc_lo_in;
   logic [6:0]   word_cnt_ff, word_cnt_in;
   logic         extract_ff, extract_in;

   logic         advance;
   logic         res_valid;
   rsp_item_type res;
   logic [7:0]   b;
   logic [8:0]   total;
   logic         total_ok;
   logic [9:0]   pos_plus2;
   logic [6:0]   nwords;
   logic [8:0]   body_len;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign b         = in_item_ff.rx_byte;
   assign pos_plus2 = {1'b0, pos_ff} + 10'd2;
   assign body_len  = exp_len_ff - LEN_OVERHEAD;
   assign nwords    = body_len[7:1];

   // frame length from function code and, for read codes, the byte count
   always_comb begin
      total    = LEN_EXCEPTION;
      total_ok = 1'b1;
      priority if (code_ff == FC_READ_COILS || code_ff == FC_READ_DISCRETE ||
                   code_ff == FC_READ_HOLDING || code_ff == FC_READ_INPUT ||
                   code_ff == FC_ENCAP) begin
         total = LEN_OVERHEAD + {1'b0, b};
      end else if (code_ff == FC_WRITE_COIL || code_ff == FC_WRITE_REG ||
                   code_ff == FC_DIAG || code_ff == FC_WRITE_COILS ||
                   code_ff == FC_WRITE_REGS) begin
         total = LEN_FIXED;
      end else if ((code_ff & FC_EXCEPTION_BIT) != 8'h00) begin
         total = LEN_EXCEPTION;
      end else begin
         total_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      exp_len_in  = exp_len_ff;
      addr_in     = addr_ff;
      code_in     = code_ff;
      hi_in       = hi_ff;
      crc_lo_in   = crc_lo_ff;
      word_cnt_in = word_cnt_ff;
      extract_in  = extract_ff;

      res_valid     = 1'b0;
      res.kind      = KIND_STATUS;
      res.reg_index = 7'd0;
      res.reg_value = 16'd0;
      res.status    = ST_OK;
      res.frame_len = 9'd0;
      res.slave_addr = addr_ff;
      res.code_byte  = code_ff;

      unique case (in_item_ff.action)
         ACT_FLUSH: begin
            phase_in    = PH_IDLE;
            pos_in      = 9'd0;
            crc_in      = CRC_INIT;
            exp_len_in  = 9'd0;
            addr_in     = 8'd0;
            code_in     = 8'd0;
            hi_in       = 8'd0;
            crc_lo_in   = 8'd0;
            word_cnt_in = 7'd0;
            extract_in  = 1'b0;
         end
         ACT_TIMEOUT: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_HEADER) begin
               phase_in   = PH_DONE;
               res_valid  = 1'b1;
               res.status = ST_HDR_TIMEOUT;
            end else if (phase_ff == PH_BODY) begin
               phase_in   = PH_DONE;
               res_valid  = 1'b1;
               res.status = ST_BODY_TIMEOUT;
            end
         end
         ACT_BYTE: begin
            if (phase_ff != PH_DONE) begin
               pos_in = pos_ff + 9'd1;
               if (phase_ff == PH_IDLE || phase_ff == PH_HEADER) begin
                  crc_in = crc16_byte(crc_ff, b);
                  if (pos_ff == 9'd0) begin
                     addr_in  = b;
                     phase_in = PH_HEADER;
                  end else if (pos_ff == 9'd1) begin
                     code_in = b;
                  end else if (!total_ok) begin
                     phase_in   = PH_DONE;
                     res_valid  = 1'b1;
                     res.status = ST_UNSUPPORTED;
                  end else if (total > max_len_ff) begin
                     phase_in   = PH_DONE;
                     res_valid  = 1'b1;
                     res.status = ST_TOO_LONG;
                  end else begin
                     exp_len_in  = total;
                     extract_in  = (code_ff == FC_READ_HOLDING || code_ff == FC_READ_INPUT) &&
                                   ({1'b0, b[7:1]} <= reg_cap_ff);
                     word_cnt_in = 7'd0;
                     phase_in    = PH_BODY;
                  end
               end else if (pos_plus2 < {1'b0, exp_len_ff}) begin
                  crc_in = crc16_byte(crc_ff, b);
                  if (extract_ff && pos_ff >= 9'd3 && word_cnt_ff < nwords) begin
                     if (pos_ff[0]) begin
                        hi_in = b;
                     end else begin
                        word_cnt_in   = word_cnt_ff + 7'd1;
                        res_valid     = 1'b1;
                        res.kind      = KIND_WORD;
                        res.reg_index = word_cnt_ff;
                        res.reg_value = {hi_ff, b};
                     end
                  end
               end else if (pos_plus2 == {1'b0, exp_len_ff}) begin
                  crc_lo_in = b;
               end else begin
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
                  if (crc_lo_ff == crc_ff[7:0] && b == crc_ff[15:8]) begin
                     res.status    = ST_OK;
                     res.frame_len = exp_len_ff;
                  end else begin
                     res.status = ST_CRC_ERROR;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         rsp_item_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_FRAME_LEN_RESET;
         reg_cap_ff   <= REG_CAPACITY_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         pos_ff       <= 9'd0;
         crc_ff       <= CRC_INIT;
         exp_len_ff   <= 9'd0;
         addr_ff      <= 8'd0;
         code_ff      <= 8'd0;
         hi_ff        <= 8'd0;
         crc_lo_ff    <= 8'd0;
         word_cnt_ff  <= 7'd0;
         extract_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAX_FRAME_LEN: max_len_ff <= csr_wdata;
               CSR_REG_CAPACITY:  reg_cap_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            phase_ff    <= phase_in;
            pos_ff      <= pos_in;
            crc_ff      <= crc_in;
            exp_len_ff  <= exp_len_in;
            addr_ff     <= addr_in;
            code_ff     <= code_in;
            hi_ff       <= hi_in;
            crc_lo_ff   <= crc_lo_in;
            word_cnt_ff <= word_cnt_in;
            extract_ff  <= extract_in;
         end
      end
   end

   `ASSERT_IMPLIES(a_status_no_word, clock, reset,
      rsp_valid && rsp_item.kind == KIND_STATUS,
      rsp_item.reg_value == 16'd0 && rsp_item.reg_index == 7'd0)
   `ASSERT_IMPLIES(a_word_no_status, clock, reset,
      rsp_valid && rsp_item.kind == KIND_WORD,
      rsp_item.status == ST_OK && rsp_item.frame_len == 9'd0)
   `ASSERT_IMPLIES(a_ok_len, clock, reset,
      rsp_valid && rsp_item.kind == KIND_STATUS && rsp_item.status == ST_OK,
      rsp_item.frame_len >= LEN_OVERHEAD)
   `ASSERT_NEXT(a_status_ends_frame, clock, reset,
      advance && res_valid && res.kind == KIND_STATUS,
      phase_ff == PH_DONE)

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives modbus rtu reply items (bytes, timeouts, flushes) into the parser
// and compares every register word and frame status with a cycle-free
// model of the parser kept in a small scoreboard; both channels idle and
// stall at random, and both csr registers are swept through several settings
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import mrrp_pkg::*;

   localparam logic [1:0] ACT_NONE  = 2'd3;
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT   = 9;

   class reply_tracker;
      logic [8:0]   max_len;
      logic [7:0]   reg_cap;
      logic [1:0]   phase;
      logic [8:0]   pos;
      logic [15:0]  crc;
      logic [8:0]   exp_len;
      logic [7:0]   addr;
      logic [7:0]   code;
      logic [7:0]   hi;
      logic [7:0]   crc_lo;
      logic [6:0]   words;
      bit           extract;
      rsp_item_type pending_results[$];
      int           mismatches;

      function new();
         max_len = MAX_FRAME_LEN_RESET;
         reg_cap = REG_CAPACITY_RESET;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = PH_IDLE;
         pos = '0;
         crc = CRC_INIT;
         exp_len = '0;
         addr = '0;
         code = '0;
         hi = '0;
         crc_lo = '0;
         words = '0;
         extract = 1'b0;
      endfunction

      static function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
         logic [15:0] v;
         v = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
         end
         return v;
      endfunction

      function void write_reg(input logic idx, input logic [8:0] data);
         if (idx == CSR_MAX_FRAME_LEN) begin
            max_len = data;
         end else begin
            reg_cap = data[7:0];
         end
      endfunction

      function void push_result(input logic kind, input logic [6:0] idx,
                                input logic [15:0] value, input logic [2:0] st,
                                input logic [8:0] len);
         rsp_item_type r;
         r.kind = kind;
         r.reg_index = idx;
         r.reg_value = value;
         r.status = st;
         r.frame_len = len;
         r.slave_addr = addr;
         r.code_byte = code;
         pending_results.push_back(r);
         if (kind == KIND_STATUS) begin
            phase = PH_DONE;
         end
      endfunction

      function void feed_item(input req_item_type it);
         logic [8:0] p;
         logic [7:0] b;
         logic [9:0] total;
         logic [6:0] nwords;
         p = pos;
         b = it.rx_byte;
         if (it.action == ACT_FLUSH) begin
            clear_frame();
            return;
         end
         if (it.action == ACT_TIMEOUT) begin
            if (phase == PH_IDLE || phase == PH_HEADER) begin
               push_result(KIND_STATUS, '0, '0, ST_HDR_TIMEOUT, '0);
            end else if (phase == PH_BODY) begin
               push_result(KIND_STATUS, '0, '0, ST_BODY_TIMEOUT, '0);
            end
            return;
         end
         if (it.action == ACT_NONE || phase == PH_DONE) begin
            return;
         end
         pos = p + 9'd1;
         if (phase != PH_BODY) begin
            crc = crc_next(crc, b);
            if (p == 9'd0) begin
               addr = b;
               phase = PH_HEADER;
               return;
            end
            if (p == 9'd1) begin
               code = b;
               return;
            end
            case (code)
               FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
               FC_ENCAP: begin
                  total = {1'b0, LEN_OVERHEAD} + {2'b00, b};
               end
               FC_WRITE_COIL, FC_WRITE_REG, FC_DIAG, FC_WRITE_COILS,
               FC_WRITE_REGS: begin
                  total = {1'b0, LEN_FIXED};
               end
               default: begin
                  if ((code & FC_EXCEPTION_BIT) != 8'h00) begin
                     total = {1'b0, LEN_EXCEPTION};
                  end else begin
                     push_result(KIND_STATUS, '0, '0, ST_UNSUPPORTED, '0);
                     return;
                  end
               end
            endcase
            if (total > {1'b0, max_len}) begin
               push_result(KIND_STATUS, '0, '0, ST_TOO_LONG, '0);
               return;
            end
            exp_len = total[8:0];
            extract = (code == FC_READ_HOLDING || code == FC_READ_INPUT) &&
                      ((b >> 1) <= reg_cap);
            words = '0;
            phase = PH_BODY;
            return;
         end
         if (int'(p) + 2 < int'(exp_len)) begin
            crc = crc_next(crc, b);
            if (extract && p >= 9'd3) begin
               nwords = 7'((exp_len - LEN_OVERHEAD) >> 1);
               if (words < nwords) begin
                  if (p[0]) begin
                     hi = b;
                  end else begin
                     push_result(KIND_WORD, words, {hi, b}, ST_OK, '0);
                     words = words + 7'd1;
                  end
               end
            end
            return;
         end
         if (int'(p) + 2 == int'(exp_len)) begin
            crc_lo = b;
            return;
         end
         if (crc_lo == crc[7:0] && b == crc[15:8]) begin
            push_result(KIND_STATUS, '0, '0, ST_OK, exp_len);
         end else begin
            push_result(KIND_STATUS, '0, '0, ST_CRC_ERROR, '0);
         end
      endfunction

      function void check_item(input rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result item: kind %0d index %0d value %h status %0d",
                        got.kind, got.reg_index, got.reg_value, got.status);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.reg_index !== want.reg_index ||
             got.reg_value !== want.reg_value || got.status !== want.status ||
             got.frame_len !== want.frame_len || got.slave_addr !== want.slave_addr ||
             got.code_byte !== want.code_byte) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("expected: kind %0d index %0d value %h status %0d len %0d addr %h fc %h",
                        want.kind, want.reg_index, want.reg_value, want.status,
                        want.frame_len, want.slave_addr, want.code_byte);
               $display("actual:   kind %0d index %0d value %h status %0d len %0d addr %h fc %h",
                        got.kind, got.reg_index, got.reg_value, got.status,
                        got.frame_len, got.slave_addr, got.code_byte);
            end
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [8:0]   csr_wdata = '0;

   reply_tracker sb = new();
   logic [7:0]   frame_bytes[$];
   bit           tx_calm = 1'b1;
   bit           rx_calm = 1'b1;
   int           stall_left = 0;
   int           cycles = 0;
   int           items_sent = 0;

   modbus_rtu_response_parser_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // result side: check accepted items, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_item(rsp_item);
            stall_left = rx_calm ? 0 : $urandom_range(0, 18);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic send(input logic [1:0] act, input logic [7:0] b);
      req_item_type it;
      int gap;
      it.action = act;
      it.rx_byte = b;
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      sb.feed_item(it);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [8:0] len, input logic [8:0] cap_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAX_FRAME_LEN;
      csr_wdata <= len;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_MAX_FRAME_LEN, len);
      csr_index <= CSR_REG_CAPACITY;
      csr_wdata <= cap_word;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_REG_CAPACITY, cap_word);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void append_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_bytes[i]) begin
         c = reply_tracker::crc_next(c, frame_bytes[i]);
      end
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   task automatic send_random_frame();
      logic [7:0] fc;
      int r;
      int cnt;
      int cut;
      int n;
      bit end_timeout;
      bit end_abort;
      frame_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 60) begin
         fc = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
      end else if (r < 72) begin
         case ($urandom_range(0, 2))
            0: fc = FC_READ_COILS;
            1: fc = FC_READ_DISCRETE;
            default: fc = FC_ENCAP;
         endcase
      end else if (r < 84) begin
         case ($urandom_range(0, 4))
            0: fc = FC_WRITE_COIL;
            1: fc = FC_WRITE_REG;
            2: fc = FC_DIAG;
            3: fc = FC_WRITE_COILS;
            default: fc = FC_WRITE_REGS;
         endcase
      end else if (r < 92) begin
         fc = FC_EXCEPTION_BIT | 8'($urandom_range(0, 127));
      end else begin
         fc = 8'($urandom_range(0, 255));
      end
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(fc);
      r = $urandom_range(0, 99);
      cnt = (r < 85) ? $urandom_range(0, 12) :
            (r < 95) ? $urandom_range(13, 60) : $urandom_range(61, 255);
      case (fc)
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_ENCAP: begin
            frame_bytes.push_back(8'(cnt));
            repeat (cnt) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAG, FC_WRITE_COILS, FC_WRITE_REGS: begin
            repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            repeat (fc[7] ? 1 : $urandom_range(0, 6)) begin
               frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
      endcase
      append_crc();
      end_timeout = 1'b0;
      end_abort = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         n = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[n] = frame_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
      end else if (r < 22) begin
         cut = $urandom_range(0, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         if (r < 18) begin
            end_timeout = 1'b1;
         end else begin
            end_abort = 1'b1;
         end
      end
      foreach (frame_bytes[i]) begin
         if ($urandom_range(0, 24) == 0) begin
            send(ACT_NONE, 8'($urandom_range(0, 255)));
         end
         send(ACT_BYTE, frame_bytes[i]);
      end
      if (end_timeout) begin
         send(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
      end else if (!end_abort && $urandom_range(0, 6) == 0) begin
         send(ACT_BYTE, 8'($urandom_range(0, 255)));
         send(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
      end
      send(ACT_FLUSH, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [8:0] len;
      logic [7:0] cap;
      int phase_end;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: timeouts, unsupported code, ignored items, odd count, exception
      send(ACT_TIMEOUT, 8'h00);
      send(ACT_FLUSH, 8'hFF);
      frame_bytes = {8'h00, 8'h07, 8'hFF};
      foreach (frame_bytes[i]) send(ACT_BYTE, frame_bytes[i]);
      send(ACT_BYTE, 8'hFF);
      send(ACT_TIMEOUT, 8'h00);
      send(ACT_FLUSH, 8'h00);
      frame_bytes = {8'hFF, FC_READ_HOLDING, 8'h03, 8'hFF, 8'hFF, 8'h00};
      append_crc();
      send(ACT_NONE, 8'h55);
      foreach (frame_bytes[i]) send(ACT_BYTE, frame_bytes[i]);
      send(ACT_FLUSH, 8'h00);
      frame_bytes = {8'h11, 8'h81, 8'h02};
      append_crc();
      foreach (frame_bytes[i]) send(ACT_BYTE, frame_bytes[i]);
      send(ACT_FLUSH, 8'h00);
      send(ACT_BYTE, 8'h01);
      send(ACT_TIMEOUT, 8'hFF);
      send(ACT_FLUSH, 8'h00);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin len = 9'd300; cap = 8'd160; end
            1: begin len = 9'd5;   cap = 8'd0;   end
            2: begin len = 9'd0;   cap = 8'd255; end
            3: begin len = 9'd511; cap = 8'd1;   end
            4: begin len = 9'd8;   cap = 8'd2;   end
            5: begin len = 9'd4;   cap = 8'd160; end
            6: begin len = 9'd40;  cap = 8'd7;   end
            7: begin len = 9'd260; cap = 8'd255; end
            default: begin
               len = 9'($urandom_range(5, 300));
               cap = 8'($urandom_range(0, 160));
            end
         endcase
         drain();
         configure(len, {1'($urandom_range(0, 1)), cap});
         phase_end = items_sent + ((len < 9'd5) ? 60 : 230);
         while (items_sent < phase_end) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 33) == 0) begin
               drain();
            end
            if ($urandom_range(0, 19) == 0) begin
               // noise: arbitrary actions and bytes
               repeat ($urandom_range(1, 10)) begin
                  send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
               end
               send(ACT_FLUSH, 8'($urandom_range(0, 255)));
            end else begin
               send_random_frame();
            end
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
